FILE: hdl/tlpt_pkg.sv
package tlpt_pkg;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_REMOVE   = 4'd1;
  localparam logic [3:0] OP_ASSIGN   = 4'd2;
  localparam logic [3:0] OP_FINISH   = 4'd3;
  localparam logic [3:0] OP_FAIL     = 4'd4;
  localparam logic [3:0] OP_CANCEL   = 4'd5;
  localparam logic [3:0] OP_REASSIGN = 4'd6;
  localparam logic [3:0] OP_CLEAR    = 4'd7;
  localparam logic [3:0] OP_LOOKUP   = 4'd8;
  localparam logic [3:0] OP_NEXT     = 4'd9;

  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_EXECUTING = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd2;
  localparam logic [2:0] ST_FAILED    = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_INVALID   = 3'd1;
  localparam logic [2:0] ERR_DUPLICATE = 3'd2;
  localparam logic [2:0] ERR_NOT_FOUND = 3'd3;
  localparam logic [2:0] ERR_STATE     = 3'd4;
  localparam logic [2:0] ERR_TERMINAL  = 3'd5;
  localparam logic [2:0] ERR_FULL      = 3'd6;

  localparam int          NUM_STATUS = 5;
  localparam logic [16:0] ROBOT_NONE = 17'h1FFFF;

  typedef logic [4:0] count_t;

  typedef struct packed {
    count_t total;
    count_t pending;
    count_t executing;
    count_t completed;
    count_t failed;
    count_t cancelled;
  } counts_t;

  typedef struct packed {
    logic       clear;
    logic       inc_en;
    logic [2:0] inc_st;
    logic       dec_en;
    logic [2:0] dec_st;
    logic       total_inc;
    logic       total_dec;
  } cnt_upd_t;

endpackage

FILE: hdl/tlpt_ram.sv
module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tlpt_counts.sv
module tlpt_counts (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tlpt_pkg::cnt_upd_t upd,
  output tlpt_pkg::counts_t counts_next
);

  tlpt_pkg::count_t st_cnt [tlpt_pkg::NUM_STATUS];
  tlpt_pkg::count_t st_cnt_next [tlpt_pkg::NUM_STATUS];
  tlpt_pkg::count_t total;
  tlpt_pkg::count_t total_next;

  always_comb begin
    for (int k = 0; k < tlpt_pkg::NUM_STATUS; k++) begin
      st_cnt_next[k] = st_cnt[k];
      if (en) begin
        if (upd.clear) begin
          st_cnt_next[k] = '0;
        end else begin
          if (upd.inc_en && upd.inc_st == 3'(k)) begin
            st_cnt_next[k] = st_cnt_next[k] + 5'd1;
          end
          if (upd.dec_en && upd.dec_st == 3'(k)) begin
            st_cnt_next[k] = st_cnt_next[k] - 5'd1;
          end
        end
      end
    end
    total_next = total;
    if (en) begin
      if (upd.clear) begin
        total_next = '0;
      end else if (upd.total_inc) begin
        total_next = total + 5'd1;
      end else if (upd.total_dec) begin
        total_next = total - 5'd1;
      end
    end
  end

  assign counts_next.total     = total_next;
  assign counts_next.pending   = st_cnt_next[0];
  assign counts_next.executing = st_cnt_next[1];
  assign counts_next.completed = st_cnt_next[2];
  assign counts_next.failed    = st_cnt_next[3];
  assign counts_next.cancelled = st_cnt_next[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int k = 0; k < tlpt_pkg::NUM_STATUS; k++) begin
        st_cnt[k] <= '0;
      end
    end else begin
      total <= total_next;
      for (int k = 0; k < tlpt_pkg::NUM_STATUS; k++) begin
        st_cnt[k] <= st_cnt_next[k];
      end
    end
  end

endmodule

FILE: hdl/task_lifecycle_priority_table.sv
// Channel  Dir  Signals                      Payload
// s_axis   in   s_tvalid s_tready s_tdata    96-bit command
// m_axis   out  m_tvalid m_tready m_tdata    88-bit result
//
// A command is taken, the scan then reads the slot memory once per slot, a further
// step drains the last read, and the apply step applies it.
// Commands are handled one at a time; the next is taken while a result waits.
// rst clears the valid bits, the status counters and the handshake state.
// A stalled result holds the apply step; nothing is written until it moves.
module task_lifecycle_priority_table #(
  parameter int TASK_SLOTS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[3:0] task_id[35:4] initial_status[38:36] priority_req[46:39]
  // create_time[78:47] robot_id[95:79]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0] error_code[3:1] result_task_id[35:4] result_status[38:36]
  // result_robot[55:39] total_count[60:56] pending_count[65:61]
  // executing_count[70:66] completed_count[75:71] failed_count[80:76]
  // cancelled_count[85:81]
  output logic [87:0] m_tdata
);

  localparam int IW    = $clog2(TASK_SLOTS);
  localparam int ST_LO = 31;
  localparam int PR_LO = 34;
  localparam int CR_LO = PR_LO + PRIORITY_BITS;
  localparam int RB_LO = CR_LO + 32;
  localparam int W     = RB_LO + 17;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t      state;
  logic [95:0] cmd;
  logic [IW:0] cnt;
  logic        pv;
  logic [IW-1:0] pidx;
  logic [TASK_SLOTS-1:0] used;

  logic          hit, free_found, best_found;
  logic [IW-1:0] hit_idx, free_idx, best_idx;
  logic [W-1:0]  hit_rec, best_rec;

  logic          we;
  logic [IW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [W-1:0]  rdata;

  logic [3:0]  c_op;
  logic [31:0] c_id;
  logic [2:0]  c_ist;
  logic [7:0]  c_pri;
  logic [31:0] c_time;
  logic [16:0] c_robot;

  assign c_op    = cmd[3:0];
  assign c_id    = cmd[35:4];
  assign c_ist   = cmd[38:36];
  assign c_pri   = cmd[46:39];
  assign c_time  = cmd[78:47];
  assign c_robot = cmd[95:79];

  tlpt_ram #(.WIDTH(W), .DEPTH(TASK_SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[IW-1:0]),
    .rdata(rdata)
  );

  logic [30:0]              r_id;
  logic [2:0]               r_st;
  logic [PRIORITY_BITS-1:0] r_pri, b_pri;
  logic [31:0]              r_cr, b_cr;
  logic [30:0]              b_id;
  logic                     r_match, r_pend, r_better;

  assign r_id  = rdata[30:0];
  assign r_st  = rdata[PR_LO-1:ST_LO];
  assign r_pri = rdata[CR_LO-1:PR_LO];
  assign r_cr  = rdata[RB_LO-1:CR_LO];
  assign b_id  = best_rec[30:0];
  assign b_pri = best_rec[CR_LO-1:PR_LO];
  assign b_cr  = best_rec[RB_LO-1:CR_LO];

  assign r_match  = pv && used[pidx] && !c_id[31] && r_id == c_id[30:0];
  assign r_pend   = pv && used[pidx] && r_st == tlpt_pkg::ST_PENDING;
  assign r_better = !best_found || r_pri > b_pri ||
                    (r_pri == b_pri && (r_cr < b_cr || (r_cr == b_cr && r_id < b_id)));

  logic [2:0]  h_st;
  logic [16:0] h_rob;
  assign h_st  = hit_rec[PR_LO-1:ST_LO];
  assign h_rob = hit_rec[W-1:RB_LO];

  logic go;
  assign go = (state == S_APPLY) && (!m_tvalid || m_tready);

  logic        ok;
  logic [2:0]  err, res_st, new_st;
  logic [31:0] rid;
  logic [16:0] res_rob, new_rob;
  logic        set_used, clr_used, clr_all, chg;
  tlpt_pkg::cnt_upd_t upd;
  tlpt_pkg::counts_t  counts_next;

  always_comb begin
    ok       = 1'b0;
    err      = tlpt_pkg::ERR_NONE;
    rid      = '1;
    res_st   = tlpt_pkg::ST_PENDING;
    res_rob  = tlpt_pkg::ROBOT_NONE;
    new_st   = h_st;
    new_rob  = h_rob;
    set_used = 1'b0;
    clr_used = 1'b0;
    clr_all  = 1'b0;
    chg      = 1'b0;
    upd      = '0;
    unique case (c_op)
      tlpt_pkg::OP_ADD: begin
        if (c_id[31]) begin
          err = tlpt_pkg::ERR_INVALID;
        end else if (hit) begin
          err = tlpt_pkg::ERR_DUPLICATE;
        end else if (c_ist > tlpt_pkg::ST_CANCELLED) begin
          err = tlpt_pkg::ERR_STATE;
        end else if (!free_found) begin
          err = tlpt_pkg::ERR_FULL;
        end else begin
          ok       = 1'b1;
          set_used = 1'b1;
          res_st   = c_ist;
          res_rob  = (c_ist == tlpt_pkg::ST_EXECUTING) ? c_robot : tlpt_pkg::ROBOT_NONE;
          upd.inc_en    = 1'b1;
          upd.inc_st    = c_ist;
          upd.total_inc = 1'b1;
        end
      end
      tlpt_pkg::OP_REMOVE, tlpt_pkg::OP_LOOKUP: begin
        if (!hit) begin
          err = tlpt_pkg::ERR_NOT_FOUND;
        end else begin
          ok      = 1'b1;
          res_st  = h_st;
          res_rob = h_rob;
          if (c_op == tlpt_pkg::OP_REMOVE) begin
            clr_used      = 1'b1;
            upd.dec_en    = 1'b1;
            upd.dec_st    = h_st;
            upd.total_dec = 1'b1;
          end
        end
      end
      tlpt_pkg::OP_ASSIGN, tlpt_pkg::OP_FINISH, tlpt_pkg::OP_FAIL,
      tlpt_pkg::OP_CANCEL, tlpt_pkg::OP_REASSIGN: begin
        if (!hit) begin
          err = tlpt_pkg::ERR_NOT_FOUND;
        end else begin
          res_st  = h_st;
          res_rob = h_rob;
          unique case (c_op)
            tlpt_pkg::OP_ASSIGN: begin
              if (h_st != tlpt_pkg::ST_PENDING) begin
                err = tlpt_pkg::ERR_STATE;
              end else begin
                chg     = 1'b1;
                new_st  = tlpt_pkg::ST_EXECUTING;
                new_rob = c_robot;
              end
            end
            tlpt_pkg::OP_FINISH: begin
              if (h_st != tlpt_pkg::ST_EXECUTING) begin
                err = tlpt_pkg::ERR_STATE;
              end else begin
                chg    = 1'b1;
                new_st = tlpt_pkg::ST_COMPLETED;
              end
            end
            default: begin
              if (h_st == tlpt_pkg::ST_COMPLETED || h_st == tlpt_pkg::ST_FAILED ||
                  h_st == tlpt_pkg::ST_CANCELLED) begin
                err = tlpt_pkg::ERR_TERMINAL;
              end else begin
                chg = 1'b1;
                if (c_op == tlpt_pkg::OP_FAIL) begin
                  new_st = tlpt_pkg::ST_FAILED;
                end else if (c_op == tlpt_pkg::OP_CANCEL) begin
                  new_st = tlpt_pkg::ST_CANCELLED;
                end else begin
                  new_st  = tlpt_pkg::ST_PENDING;
                  new_rob = tlpt_pkg::ROBOT_NONE;
                end
              end
            end
          endcase
          if (chg) begin
            ok         = 1'b1;
            res_st     = new_st;
            res_rob    = new_rob;
            upd.dec_en = 1'b1;
            upd.dec_st = h_st;
            upd.inc_en = 1'b1;
            upd.inc_st = new_st;
          end
        end
      end
      tlpt_pkg::OP_CLEAR: begin
        ok        = 1'b1;
        clr_all   = 1'b1;
        upd.clear = 1'b1;
      end
      tlpt_pkg::OP_NEXT: begin
        if (best_found) begin
          ok      = 1'b1;
          rid     = {1'b0, b_id};
          res_st  = best_rec[PR_LO-1:ST_LO];
          res_rob = best_rec[W-1:RB_LO];
        end else begin
          err = tlpt_pkg::ERR_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = go && (set_used || chg);
    waddr = set_used ? free_idx : hit_idx;
    if (set_used) begin
      wdata = {res_rob, c_time, PRIORITY_BITS'(c_pri), c_ist, c_id[30:0]};
    end else begin
      wdata = {new_rob, hit_rec[RB_LO-1:PR_LO], new_st, hit_rec[30:0]};
    end
  end

  tlpt_counts u_counts (
    .clk        (clk),
    .rst        (rst),
    .en         (go),
    .upd        (upd),
    .counts_next(counts_next)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      used     <= '0;
      pv       <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && !go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= s_tdata;
            cnt        <= '0;
            pv         <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == (IW + 1)'(TASK_SLOTS)) begin
            pv    <= 1'b0;
            state <= S_APPLY;
          end else begin
            pv   <= 1'b1;
            pidx <= cnt[IW-1:0];
            cnt  <= cnt + 1'b1;
          end
          if (r_match) begin
            hit     <= 1'b1;
            hit_idx <= pidx;
            hit_rec <= rdata;
          end
          if (pv && !used[pidx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= pidx;
          end
          if (r_pend && r_better) begin
            best_found <= 1'b1;
            best_idx   <= pidx;
            best_rec   <= rdata;
          end
        end
        S_APPLY: begin
          if (go) begin
            if (clr_all) begin
              used <= '0;
            end else if (set_used) begin
              used[free_idx] <= 1'b1;
            end else if (clr_used) begin
              used[hit_idx] <= 1'b0;
            end
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, counts_next.cancelled, counts_next.failed,
                         counts_next.completed, counts_next.executing,
                         counts_next.pending, counts_next.total,
                         res_rob, res_st, rid, err, ok};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_apply_done: assert property (@(posedge clk) disable iff (rst)
    go |=> state == S_IDLE && m_tvalid)
    else $error("apply step did not complete");
  a_hit_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && hit) |-> used[hit_idx])
    else $error("matched slot not in use");
  a_free_unused: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && free_found) |-> !used[free_idx])
    else $error("free slot in use");
  a_best_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && best_found) |-> used[best_idx])
    else $error("pending choice not in use");
`endif

endmodule

FILE: tb/tb_task_lifecycle_priority_table.sv
module tb_task_lifecycle_priority_table;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] id;
    logic [2:0]  ist;
    logic [7:0]  pri;
    logic [31:0] ctime;
    logic [16:0] robot;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [2:0]        err;
    logic [31:0]       rid;
    logic [2:0]        rstat;
    logic [16:0]       rrob;
    tlpt_pkg::count_t  total;
    tlpt_pkg::count_t  pend;
    tlpt_pkg::count_t  exec;
    tlpt_pkg::count_t  done;
    tlpt_pkg::count_t  fail;
    tlpt_pkg::count_t  canc;
  } resp_t;

  typedef struct {
    cmd_t  cmd;
    logic  known;
    resp_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [87:0] m_tdata;

  task_lifecycle_priority_table i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow table
  logic        tbl_used [NSLOT];
  logic [31:0] tbl_id [NSLOT];
  logic [2:0]  tbl_st [NSLOT];
  logic [7:0]  tbl_pri [NSLOT];
  logic [31:0] tbl_ct [NSLOT];
  logic [16:0] tbl_rob [NSLOT];

  resp_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int quiet = 0;

  function automatic cmd_t to_cmd(logic [3:0] op, logic [31:0] id, logic [2:0] ist,
                                  logic [7:0] pri, logic [31:0] ct, logic [16:0] rob);
    cmd_t c;
    c.op = op; c.id = id; c.ist = ist; c.pri = pri; c.ctime = ct; c.robot = rob;
    return c;
  endfunction

  function automatic int find_task(logic [31:0] id);
    if (id[31]) return -1;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic is_final(logic [2:0] st);
    return st == tlpt_pkg::ST_COMPLETED || st == tlpt_pkg::ST_FAILED ||
           st == tlpt_pkg::ST_CANCELLED;
  endfunction

  function automatic resp_t apply_cmd(cmd_t c);
    resp_t r;
    int s;
    int cnt [5];
    int tot;
    r = '0;
    r.rid = '1;
    r.rrob = tlpt_pkg::ROBOT_NONE;
    s = -1;
    tot = 0;
    cnt = '{0, 0, 0, 0, 0};
    if (c.op >= tlpt_pkg::OP_REMOVE && c.op <= tlpt_pkg::OP_LOOKUP &&
        c.op != tlpt_pkg::OP_CLEAR) begin
      s = find_task(c.id);
      if (s < 0) r.err = tlpt_pkg::ERR_NOT_FOUND;
    end
    unique case (c.op)
      tlpt_pkg::OP_ADD: begin
        if (c.id[31]) r.err = tlpt_pkg::ERR_INVALID;
        else if (find_task(c.id) >= 0) r.err = tlpt_pkg::ERR_DUPLICATE;
        else if (c.ist > tlpt_pkg::ST_CANCELLED) r.err = tlpt_pkg::ERR_STATE;
        else begin
          for (int i = 0; i < NSLOT; i++)
            if (!tbl_used[i] && s < 0) s = i;
          if (s < 0) r.err = tlpt_pkg::ERR_FULL;
          else begin
            tbl_used[s] = 1; tbl_id[s] = c.id; tbl_st[s] = c.ist;
            tbl_pri[s] = c.pri; tbl_ct[s] = c.ctime;
            tbl_rob[s] = (c.ist == tlpt_pkg::ST_EXECUTING) ? c.robot : tlpt_pkg::ROBOT_NONE;
            r.ok = 1;
          end
        end
      end
      tlpt_pkg::OP_REMOVE: if (s >= 0) begin
        tbl_used[s] = 0; r.ok = 1;
      end
      tlpt_pkg::OP_ASSIGN: if (s >= 0) begin
        if (tbl_st[s] != tlpt_pkg::ST_PENDING) r.err = tlpt_pkg::ERR_STATE;
        else begin
          tbl_st[s] = tlpt_pkg::ST_EXECUTING; tbl_rob[s] = c.robot; r.ok = 1;
        end
      end
      tlpt_pkg::OP_FINISH: if (s >= 0) begin
        if (tbl_st[s] != tlpt_pkg::ST_EXECUTING) r.err = tlpt_pkg::ERR_STATE;
        else begin
          tbl_st[s] = tlpt_pkg::ST_COMPLETED; r.ok = 1;
        end
      end
      tlpt_pkg::OP_FAIL, tlpt_pkg::OP_CANCEL, tlpt_pkg::OP_REASSIGN: if (s >= 0) begin
        if (is_final(tbl_st[s])) r.err = tlpt_pkg::ERR_TERMINAL;
        else begin
          r.ok = 1;
          if (c.op == tlpt_pkg::OP_FAIL) tbl_st[s] = tlpt_pkg::ST_FAILED;
          else if (c.op == tlpt_pkg::OP_CANCEL) tbl_st[s] = tlpt_pkg::ST_CANCELLED;
          else begin
            tbl_st[s] = tlpt_pkg::ST_PENDING; tbl_rob[s] = tlpt_pkg::ROBOT_NONE;
          end
        end
      end
      tlpt_pkg::OP_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
        r.ok = 1;
      end
      tlpt_pkg::OP_LOOKUP: if (s >= 0) r.ok = 1;
      tlpt_pkg::OP_NEXT: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!tbl_used[i] || tbl_st[i] != tlpt_pkg::ST_PENDING) continue;
          if (s < 0 || tbl_pri[i] > tbl_pri[s] ||
              (tbl_pri[i] == tbl_pri[s] && (tbl_ct[i] < tbl_ct[s] ||
               (tbl_ct[i] == tbl_ct[s] && tbl_id[i] < tbl_id[s]))))
            s = i;
        end
        if (s >= 0) begin
          r.ok = 1; r.rid = tbl_id[s];
        end else r.err = tlpt_pkg::ERR_NOT_FOUND;
      end
      default: ;
    endcase
    if (s >= 0 && (r.ok || r.err == tlpt_pkg::ERR_STATE ||
                   r.err == tlpt_pkg::ERR_TERMINAL)) begin
      r.rstat = tbl_st[s];
      r.rrob = tbl_rob[s];
    end
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i]) begin
        tot++;
        if (tbl_st[i] <= tlpt_pkg::ST_CANCELLED) cnt[tbl_st[i]]++;
      end
    r.total = 5'(tot); r.pend = 5'(cnt[0]); r.exec = 5'(cnt[1]);
    r.done = 5'(cnt[2]); r.fail = 5'(cnt[3]); r.canc = 5'(cnt[4]);
    return r;
  endfunction

  // pack to port layout
  function automatic logic [95:0] pack_cmd(cmd_t c);
    return {c.robot, c.ctime, c.pri, c.ist, c.id, c.op};
  endfunction

  function automatic resp_t unpack_resp(logic [87:0] d);
    resp_t r;
    r.ok = d[0]; r.err = d[3:1]; r.rid = d[35:4]; r.rstat = d[38:36];
    r.rrob = d[55:39]; r.total = d[60:56]; r.pend = d[65:61];
    r.exec = d[70:66]; r.done = d[75:71]; r.fail = d[80:76]; r.canc = d[85:81];
    return r;
  endfunction

  task automatic send_cmd(cmd_t c);
    resp_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tdata <= pack_cmd(c);
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    p = apply_cmd(c);
    expected_q.push_back(p);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic resp_t known_resp(logic ok, logic [2:0] err, logic [2:0] st,
                                       logic [16:0] rob, int tot, int pend, int ex);
    resp_t r;
    r = '0;
    r.ok = ok; r.err = err; r.rid = '1; r.rstat = st; r.rrob = rob;
    r.total = 5'(tot); r.pend = 5'(pend); r.exec = 5'(ex);
    return r;
  endfunction

  function automatic logic [31:0] rand_id(int pool);
    return $urandom_range(pool - 1);
  endfunction

  function automatic cmd_t rand_cmd(int pool);
    cmd_t c;
    int k;
    k = $urandom_range(99);
    c.id = rand_id(pool);
    c.ist = ($urandom_range(3) == 0) ? 3'($urandom) : tlpt_pkg::ST_PENDING;
    c.pri = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    c.ctime = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom;
    c.robot = ($urandom_range(4) == 0) ? tlpt_pkg::ROBOT_NONE : 17'($urandom);
    if (k < 25) c.op = tlpt_pkg::OP_ADD;
    else if (k < 35) c.op = tlpt_pkg::OP_ASSIGN;
    else if (k < 43) c.op = tlpt_pkg::OP_FINISH;
    else if (k < 50) c.op = tlpt_pkg::OP_FAIL;
    else if (k < 56) c.op = tlpt_pkg::OP_CANCEL;
    else if (k < 63) c.op = tlpt_pkg::OP_REASSIGN;
    else if (k < 70) c.op = tlpt_pkg::OP_REMOVE;
    else if (k < 78) c.op = tlpt_pkg::OP_LOOKUP;
    else if (k < 93) c.op = tlpt_pkg::OP_NEXT;
    else if (k < 95) c.op = tlpt_pkg::OP_CLEAR;
    else if (k < 97) c.op = 4'($urandom_range(15, 10));
    else begin
      c.op = 4'($urandom_range(9));
      c.id = $urandom;
    end
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_resp(m_tdata);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      m_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("task_lifecycle_priority_table test failed");
      $finish;
    end
  end

  row_t plan[$];

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    for (int i = 0; i < NSLOT; i++) begin
      tbl_used[i] = 0; tbl_id[i] = 0; tbl_st[i] = 0;
      tbl_pri[i] = 0; tbl_ct[i] = 0; tbl_rob[i] = 0;
    end
    idle_tab = '{0, 61, 0, 24};
    stall_tab = '{0, 0, 61, 24};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    plan.push_back('{to_cmd(tlpt_pkg::OP_NEXT, 0, 0, 0, 0, 0), 1,
                     known_resp(0, tlpt_pkg::ERR_NOT_FOUND, 0, tlpt_pkg::ROBOT_NONE,
                                0, 0, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_LOOKUP, 5, 0, 0, 0, 0), 1,
                     known_resp(0, tlpt_pkg::ERR_NOT_FOUND, 0, tlpt_pkg::ROBOT_NONE,
                                0, 0, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 32'h8000_0000, 0, 0, 0, 0), 1,
                     known_resp(0, tlpt_pkg::ERR_INVALID, 0, tlpt_pkg::ROBOT_NONE,
                                0, 0, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 32'h7FFF_FFFF, tlpt_pkg::ST_PENDING, 8'hFF,
                            32'hFFFF_FFFF, 17'h0FFFF), 1,
                     known_resp(1, tlpt_pkg::ERR_NONE, tlpt_pkg::ST_PENDING,
                                tlpt_pkg::ROBOT_NONE, 1, 1, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 32'h7FFF_FFFF, 0, 0, 0, 0), 1,
                     known_resp(0, tlpt_pkg::ERR_DUPLICATE, 0, tlpt_pkg::ROBOT_NONE,
                                1, 1, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 1, 3'd7, 0, 0, 0), 1,
                     known_resp(0, tlpt_pkg::ERR_STATE, 0, tlpt_pkg::ROBOT_NONE,
                                1, 1, 0)});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 0, tlpt_pkg::ST_EXECUTING, 0, 0, 17'h10000),
                     0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 2, tlpt_pkg::ST_PENDING, 8'hFF, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 3, tlpt_pkg::ST_PENDING, 8'hFF, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_NEXT, 0, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ASSIGN, 2, 0, 0, 0, 17'h0FFFF), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ASSIGN, 2, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_FINISH, 3, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_FINISH, 2, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_FAIL, 2, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_FAIL, 0, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_CANCEL, 3, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_REASSIGN, 3, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_ADD, 9, tlpt_pkg::ST_EXECUTING, 1, 7, 17'h1FFFF),
                     0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_REASSIGN, 9, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_REMOVE, 9, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(4'd15, 1, 0, 0, 0, 0), 0, '0});
    plan.push_back('{to_cmd(tlpt_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0, '0});
    foreach (plan[i]) begin
      send_cmd(plan[i].cmd);
      if (plan[i].known && expected_q[$] !== plan[i].want) begin
        errors++;
        if (errors <= 10) $display("row %0d: predictor disagrees with table", i);
      end
    end

    // fill past capacity: full table flag
    for (int i = 0; i < NSLOT + 2; i++)
      send_cmd(to_cmd(tlpt_pkg::OP_ADD, 100 + i, 3'($urandom_range(4)),
               8'($urandom_range(2)), 32'($urandom_range(2)), 17'($urandom)));
    for (int i = 0; i < 6; i++) send_cmd(to_cmd(tlpt_pkg::OP_NEXT, 0, 0, 0, 0, 0));
    drain;
    send_cmd(to_cmd(tlpt_pkg::OP_CLEAR, 0, 0, 0, 0, 0));

    // long receiver stall while commands keep coming
    hold_req <= hold_req + 1;
    for (int i = 0; i < 8; i++) send_cmd(rand_cmd(24));
    drain;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int i = 0; i < 100; i++) send_cmd(rand_cmd((ph % 2 == 0) ? 24 : 12));
      drain;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain;
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("task_lifecycle_priority_table test passed");
    else
      $display("task_lifecycle_priority_table test failed");
    $finish;
  end

endmodule
